>>> design/sync_len_xor_packet_deframer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sync/length/XOR packet deframer
// Short forms for the clocked property checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef SYNC_LEN_XOR_PACKET_DEFRAMER_MACROS_SVH
`define SYNC_LEN_XOR_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SLD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sld_pkg.sv
// ---------------------------------------------------------------------------
// sld_pkg
// Shared types and constants of the sync/length/XOR packet deframer.
// ---------------------------------------------------------------------------
package sld_pkg;

  // Default payload store depth in bytes.
  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  // Configuration register reset values.
  localparam logic [7:0] SYNC_RESET    = 8'hAA;
  localparam logic [7:0] TIMEOUT_RESET = 8'd50;

  // Configuration register indexes.
  localparam logic CFG_SYNC    = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Input item kinds carried on tuser.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Frame parser phase.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_t;

  // Top-level mode: taking input, or replaying a good frame.
  typedef enum logic {
    MODE_PARSE  = 1'b0,
    MODE_REPLAY = 1'b1
  } mode_t;

  // Control from the parser to the store and replay logic.
  typedef struct packed {
    logic wr_en;       // write one payload byte into the store
    logic frame_good;  // checksum matched, start replay
  } sld_ctl_t;

endpackage

>>> design/sync_len_xor_packet_deframer.sv
// ---------------------------------------------------------------------------
// sync_len_xor_packet_deframer
// Deframes sync/type/length/payload/XOR-checksum packets from a byte stream
// and replays each good packet as one result per payload byte, or one empty result.
// ---------------------------------------------------------------------------
// Bytes and ticks are taken whenever the deframer is parsing. After the
// checksum byte of a good frame the input stalls while the payload is read
// back from the single-port payload memory, one byte per cycle while the
// output is not stalled; the input is held until the last result of the
// frame is loaded. Bad frames, aborted frames and ticks cause no stall.
// The payload memory needs no clearing after reset; replay only reads bytes
// written by the same frame.
`include "sync_len_xor_packet_deframer_macros.svh"

module sync_len_xor_packet_deframer #(
  parameter int unsigned MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] rx_byte
  input  logic        s_tuser,    // [0] kind
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [7:0] pkt_type, [14:8] pkt_len,
                                  // [22:15] payload_byte, [23] zero
  output logic        m_tuser,    // [0] byte_valid
  output logic        m_tlast,    // is_last
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]         sync_byte, timeout_ticks;
  logic               in_req, byte_req, tick_req;
  sld_pkg::sld_ctl_t  ctl;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [7:0]         wr_data, rd_data;
  logic [7:0]         held_type;
  logic [LEN_W-1:0]   held_len;
  sld_pkg::mode_t     mode, mode_next;
  logic [LEN_W-1:0]   rd_idx, rd_idx_next;
  logic               rd_en, load, last;
  logic [LEN_W:0]     idx_inc;

  // Payload memory with a registered read port.
  logic [7:0] payload_store [MAX_PAYLOAD];

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte     <= sld_pkg::SYNC_RESET;
      timeout_ticks <= sld_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sld_pkg::CFG_SYNC:    sync_byte     <= cfg_data;
        sld_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data;
        default:              sync_byte     <= sync_byte;
      endcase
    end
  end

  // Input requests are taken only while parsing.
  assign s_tready = (mode == sld_pkg::MODE_PARSE);
  assign in_req   = s_tvalid && s_tready;
  assign byte_req = in_req && (s_tuser == sld_pkg::KIND_BYTE);
  assign tick_req = in_req && (s_tuser == sld_pkg::KIND_TICK);

  sld_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .LEN_W       (LEN_W),
    .ADDR_W      (ADDR_W)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .byte_req      (byte_req),
    .tick_req      (tick_req),
    .rx_byte       (s_tdata),
    .sync_byte     (sync_byte),
    .timeout_ticks (timeout_ticks),
    .ctl           (ctl),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .held_type     (held_type),
    .held_len      (held_len)
  );

  // Replay control: one memory read ahead of the output register.
  assign load    = (mode == sld_pkg::MODE_REPLAY) && (!m_tvalid || m_tready);
  assign idx_inc = {1'b0, rd_idx} + {{LEN_W{1'b0}}, 1'b1};
  assign last    = (held_len == '0) || (idx_inc == {1'b0, held_len});

  always_comb begin
    mode_next   = mode;
    rd_idx_next = rd_idx;
    case (mode)
      sld_pkg::MODE_PARSE: begin
        if (ctl.frame_good) begin
          mode_next   = sld_pkg::MODE_REPLAY;
          rd_idx_next = '0;
        end
      end
      sld_pkg::MODE_REPLAY: begin
        if (load) begin
          if (last) begin
            mode_next = sld_pkg::MODE_PARSE;
          end else begin
            rd_idx_next = idx_inc[LEN_W-1:0];
          end
        end
      end
      default: mode_next = sld_pkg::MODE_PARSE;
    endcase
  end

  assign rd_en   = ctl.frame_good || (load && !last);
  assign rd_addr = ctl.frame_good ? '0 : idx_inc[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= sld_pkg::MODE_PARSE;
      rd_idx <= '0;
    end else begin
      mode   <= mode_next;
      rd_idx <= rd_idx_next;
    end
  end

  // Payload memory: parser writes, replay reads; never both in one cycle.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      payload_store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= payload_store[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata[7:0]   <= held_type;
      m_tdata[14:8]  <= 7'(held_len);
      m_tdata[22:15] <= (held_len == '0) ? 8'd0 : rd_data;
      m_tdata[23]    <= 1'b0;
      m_tuser        <= (held_len != '0);
      m_tlast        <= last;
    end
  end

  // Checks on the store and replay sequencing.
  `SLD_ASSERT_IMPL(a_no_write_in_replay, clk, rst, mode == sld_pkg::MODE_REPLAY, !ctl.wr_en, "payload write during replay")
  `SLD_ASSERT_NEXT(a_good_starts_replay, clk, rst, ctl.frame_good, mode == sld_pkg::MODE_REPLAY, "good frame did not start replay")
  `SLD_ASSERT_IMPL(a_idx_in_range, clk, rst, mode == sld_pkg::MODE_REPLAY && held_len != '0, rd_idx < held_len, "replay index past packet length")
  `SLD_ASSERT_IMPL(a_empty_is_last, clk, rst, m_tvalid && !m_tuser, m_tlast && m_tdata[14:8] == 7'd0, "empty result not marked last")

endmodule

>>> design/sld_parser.sv
// ---------------------------------------------------------------------------
// sld_parser
// Byte-by-byte frame parser: sync, type, length, payload, XOR checksum,
// with an inter-byte timeout measured in ticks.
// ---------------------------------------------------------------------------
module sld_parser #(
  parameter int unsigned MAX_PAYLOAD = sld_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1),
  parameter int unsigned ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_req,     // a received byte is accepted
  input  logic               tick_req,     // a tick is accepted
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         sync_byte,
  input  logic [7:0]         timeout_ticks,
  output sld_pkg::sld_ctl_t  ctl,
  output logic [ADDR_W-1:0]  wr_addr,
  output logic [7:0]         wr_data,
  output logic [7:0]         held_type,
  output logic [LEN_W-1:0]   held_len
);

  sld_pkg::phase_t   phase, phase_next, phase_eff;
  logic [7:0]        running_xor, running_xor_next;
  logic [7:0]        held_type_next;
  logic [LEN_W-1:0]  held_len_next;
  logic [LEN_W-1:0]  write_offset, write_offset_next;
  logic [7:0]        gap_ticks, gap_ticks_next;
  logic [LEN_W:0]    offset_inc;
  logic              sync_hit;

  // Phase as seen by the incoming byte: unused codes and a stale frame
  // both fall back to idle.
  always_comb begin
    case (phase)
      sld_pkg::PH_IDLE:  phase_eff = sld_pkg::PH_IDLE;
      sld_pkg::PH_TYPE,
      sld_pkg::PH_LEN,
      sld_pkg::PH_DATA,
      sld_pkg::PH_CHECK: phase_eff = (gap_ticks > timeout_ticks) ? sld_pkg::PH_IDLE : phase;
      default:           phase_eff = sld_pkg::PH_IDLE;
    endcase
  end

  assign sync_hit   = (rx_byte == sync_byte);
  assign offset_inc = {1'b0, write_offset} + {{LEN_W{1'b0}}, 1'b1};

  // Next state of the phase and the frame registers.
  always_comb begin
    phase_next        = phase;
    running_xor_next  = running_xor;
    held_type_next    = held_type;
    held_len_next     = held_len;
    write_offset_next = write_offset;
    if (byte_req) begin
      phase_next = phase_eff;
      if (sync_hit && (phase_eff == sld_pkg::PH_TYPE || phase_eff == sld_pkg::PH_LEN)) begin
        // A sync byte in the header restarts the frame.
        phase_next        = sld_pkg::PH_TYPE;
        running_xor_next  = '0;
        write_offset_next = '0;
      end else begin
        case (phase_eff)
          sld_pkg::PH_IDLE: begin
            if (sync_hit) begin
              phase_next       = sld_pkg::PH_TYPE;
              running_xor_next = '0;
            end
          end
          sld_pkg::PH_TYPE: begin
            held_type_next   = rx_byte;
            running_xor_next = running_xor ^ rx_byte;
            phase_next       = sld_pkg::PH_LEN;
          end
          sld_pkg::PH_LEN: begin
            if (rx_byte > 8'(MAX_PAYLOAD)) begin
              phase_next = sld_pkg::PH_IDLE;
            end else begin
              held_len_next     = rx_byte[LEN_W-1:0];
              running_xor_next  = running_xor ^ rx_byte;
              write_offset_next = '0;
              phase_next = (rx_byte == 8'd0) ? sld_pkg::PH_CHECK : sld_pkg::PH_DATA;
            end
          end
          sld_pkg::PH_DATA: begin
            write_offset_next = offset_inc[LEN_W-1:0];
            running_xor_next  = running_xor ^ rx_byte;
            if (offset_inc >= {1'b0, held_len}) begin
              phase_next = sld_pkg::PH_CHECK;
            end
          end
          sld_pkg::PH_CHECK: phase_next = sld_pkg::PH_IDLE;
          default:           phase_next = sld_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Outputs: store writes and the good-frame strobe.
  always_comb begin
    ctl.wr_en      = 1'b0;
    ctl.frame_good = 1'b0;
    if (byte_req && !(sync_hit && (phase_eff == sld_pkg::PH_TYPE ||
                                   phase_eff == sld_pkg::PH_LEN))) begin
      case (phase_eff)
        sld_pkg::PH_DATA:  ctl.wr_en      = ({1'b0, write_offset} < (LEN_W + 1)'(MAX_PAYLOAD));
        sld_pkg::PH_CHECK: ctl.frame_good = (rx_byte == running_xor);
        default: begin
          ctl.wr_en      = 1'b0;
          ctl.frame_good = 1'b0;
        end
      endcase
    end
  end

  assign wr_addr = write_offset[ADDR_W-1:0];
  assign wr_data = rx_byte;

  // Gap counter: ticks count up and saturate, bytes clear it.
  always_comb begin
    gap_ticks_next = gap_ticks;
    if (byte_req) begin
      gap_ticks_next = '0;
    end else if (tick_req && gap_ticks != 8'hFF) begin
      gap_ticks_next = gap_ticks + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sld_pkg::PH_IDLE;
      running_xor  <= '0;
      held_type    <= '0;
      held_len     <= '0;
      write_offset <= '0;
      gap_ticks    <= '0;
    end else begin
      phase        <= phase_next;
      running_xor  <= running_xor_next;
      held_type    <= held_type_next;
      held_len     <= held_len_next;
      write_offset <= write_offset_next;
      gap_ticks    <= gap_ticks_next;
    end
  end

endmodule
